FILE: src/discrete_laplacian_stencil_top_assert.svh
// Assertion macros for the discrete Laplacian stencil block.
// Used by the port checker; depends on nothing else.
`ifndef DISCRETE_LAPLACIAN_STENCIL_TOP_ASSERT_SVH
`define DISCRETE_LAPLACIAN_STENCIL_TOP_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define DLS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stencil check failed: same-cycle rule");

// A condition that must hold in the cycle after its trigger.
`define DLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stencil check failed: next-cycle rule");

// A condition that must hold in the cycle after reset is seen.
`define DLS_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("stencil check failed: reset rule");

`endif

FILE: src/dls_pkg.sv
// Shared types and constants of the discrete Laplacian stencil block.
// No dependencies; src files use scoped names, the testbench imports it.
package dls_pkg;

   // Geometry and number formats.
   localparam int MAX_COLS     = 1024;
   localparam int MAX_ROWS     = 1024;
   localparam int SAMPLE_BITS  = 16;
   localparam int COL_BITS     = $clog2(MAX_COLS);
   localparam int ROW_BITS     = $clog2(MAX_ROWS);
   localparam int DIM_BITS     = 11;
   localparam int GAIN_BITS    = 16;
   localparam int VALUE_BITS   = 32;
   localparam int IDX_BITS     = 3;

   // Kernel sum in quarter-LSB units gets six bits of headroom over a sample.
   localparam int KERNEL_BITS  = SAMPLE_BITS + 6;
   localparam int PROD_BITS    = KERNEL_BITS + GAIN_BITS + 1;
   localparam int ROUND_SHIFT  = 10;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(256);
   localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = DIM_BITS'(MAX_COLS);
   localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = DIM_BITS'(MAX_ROWS);
   localparam logic [DIM_BITS-1:0]  DIM_MIN      = DIM_BITS'(3);

   // Register indexes of the configuration port.
   typedef enum logic [IDX_BITS-1:0] {
      CSR_KERNEL_MODE  = 3'd0,
      CSR_INV_STEP_SQ  = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3
   } csr_index_type;

   // Kernel selection.
   typedef enum logic {
      KERNEL_FIVE_POINT = 1'b0,
      KERNEL_NINE_POINT = 1'b1
   } kernel_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          frame_start;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] laplace_value;
      logic [COL_BITS-1:0]          col_index;
      logic [ROW_BITS-1:0]          row_index;
      logic                         frame_end;
   } rsp_word_type;

   // Position data that travels with a result through the pipeline.
   typedef struct packed {
      logic [COL_BITS-1:0] col_index;
      logic [ROW_BITS-1:0] row_index;
      logic                frame_end;
   } meta_type;

   // One column of the 3x3 window: top is two rows up, bot is the newest row.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] top;
      logic signed [SAMPLE_BITS-1:0] mid;
      logic signed [SAMPLE_BITS-1:0] bot;
   } column_type;

   // One entry of the line store: the sample two rows up and one row up.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] upper;
      logic signed [SAMPLE_BITS-1:0] middle;
   } line_word_type;

endpackage

FILE: src/dls_line_store.sv
// Line store of the stencil block: both buffered rows in one memory word.
// Depends on dls_pkg for the word type and depth.
module dls_line_store (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [dls_pkg::COL_BITS-1:0]  rd_addr,
   output dls_pkg::line_word_type        rd_word,
   input  logic                          wr_en,
   input  logic [dls_pkg::COL_BITS-1:0]  wr_addr,
   input  dls_pkg::line_word_type        wr_word
);

   dls_pkg::line_word_type mem [dls_pkg::MAX_COLS];
   dls_pkg::line_word_type rd_word_ff;

   // Registered read; a read and write to the same entry return the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   assign rd_word = rd_word_ff;

endmodule

FILE: src/dls_cell.sv
// One cell of the window chain: holds a column of three samples.
// Depends on dls_pkg for the column type.
module dls_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  dls_pkg::column_type load_column,
   output dls_pkg::column_type held_column
);

   dls_pkg::column_type column_ff;
   dls_pkg::column_type column_in;

   // Take the neighbor's column whenever a word moves into the window.
   always_comb begin
      column_in = column_ff;
      if (shift_en) begin
         column_in = load_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

   assign held_column = column_ff;

endmodule

FILE: src/dls_kernel.sv
// Kernel arithmetic: sum, gain multiply, round and saturate, output register.
// Depends on dls_pkg for types, widths and kernel codes.
module dls_kernel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dls_pkg::column_type           win_left,
   input  dls_pkg::column_type           win_center,
   input  dls_pkg::column_type           win_right,
   input  dls_pkg::meta_type             in_meta,
   input  dls_pkg::kernel_mode_type      kernel_mode,
   input  logic [dls_pkg::GAIN_BITS-1:0] inv_step_sq,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dls_pkg::rsp_word_type         rsp_word
);

   localparam int KB = dls_pkg::KERNEL_BITS;
   localparam int PB = dls_pkg::PROD_BITS;
   localparam int VB = dls_pkg::VALUE_BITS;

   logic                 k_v_ff, k_v_in;
   logic signed [KB-1:0] k_ff, k_in;
   dls_pkg::meta_type    k_meta_ff, k_meta_in;
   logic                 p_v_ff, p_v_in;
   logic signed [PB-1:0] p_ff, p_in;
   dls_pkg::meta_type    p_meta_ff, p_meta_in;
   logic                 o_v_ff, o_v_in;
   dls_pkg::rsp_word_type o_word_ff, o_word_in;

   logic                 o_rdy, p_rdy, k_rdy;
   logic signed [KB-1:0] ctr, axial, diag, k_sum;
   logic signed [PB:0]   rounded;
   logic                 fits;
   logic [VB-1:0]        sat_value;

   // Each stage moves when the one after it is empty or emptying.
   assign o_rdy    = !o_v_ff || rsp_ready;
   assign p_rdy    = !p_v_ff || o_rdy;
   assign k_rdy    = !k_v_ff || p_rdy;
   assign in_ready = k_rdy;

   // Kernel sum in quarter-LSB units.
   always_comb begin
      ctr   = KB'(win_center.mid);
      axial = KB'(win_center.top) + KB'(win_center.bot)
            + KB'(win_left.mid) + KB'(win_right.mid);
      diag  = KB'(win_left.top) + KB'(win_right.top)
            + KB'(win_left.bot) + KB'(win_right.bot);
      unique case (kernel_mode)
         dls_pkg::KERNEL_FIVE_POINT: begin
            k_sum = (axial - (ctr <<< 2)) <<< 2;
         end
         dls_pkg::KERNEL_NINE_POINT: begin
            k_sum = (axial <<< 1) + diag - (ctr <<< 3) - (ctr <<< 2);
         end
         default: begin
            k_sum = '0;
         end
      endcase
   end

   // Round half up at the Q28.10 product's point; clamp to the 32-bit range.
   always_comb begin
      rounded   = ((PB + 1)'(p_ff) + (PB + 1)'(1 << (dls_pkg::ROUND_SHIFT - 1)))
                  >>> dls_pkg::ROUND_SHIFT;
      fits      = (rounded[PB:VB-1] == '0) || (rounded[PB:VB-1] == '1);
      sat_value = {rounded[PB], {(VB - 1){~rounded[PB]}}};
   end

   // Next state of the three stages.
   always_comb begin
      k_v_in    = k_v_ff;
      k_in      = k_ff;
      k_meta_in = k_meta_ff;
      p_v_in    = p_v_ff;
      p_in      = p_ff;
      p_meta_in = p_meta_ff;
      o_v_in    = o_v_ff;
      o_word_in = o_word_ff;
      if (k_rdy) begin
         k_v_in    = in_valid;
         k_in      = k_sum;
         k_meta_in = in_meta;
      end
      if (p_rdy) begin
         p_v_in    = k_v_ff;
         p_in      = PB'(k_ff) * PB'($signed({1'b0, inv_step_sq}));
         p_meta_in = k_meta_ff;
      end
      if (o_rdy) begin
         o_v_in                  = p_v_ff;
         o_word_in.laplace_value = fits ? rounded[VB-1:0] : sat_value;
         o_word_in.col_index     = p_meta_ff.col_index;
         o_word_in.row_index     = p_meta_ff.row_index;
         o_word_in.frame_end     = p_meta_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         k_v_ff <= k_v_in;
         p_v_ff <= p_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      k_meta_ff <= k_meta_in;
      p_ff      <= p_in;
      p_meta_ff <= p_meta_in;
      o_word_ff <= o_word_in;
   end

   assign rsp_valid = o_v_ff;
   assign rsp_word  = o_word_ff;

endmodule

FILE: src/discrete_laplacian_stencil_top.sv
// Top level of the streaming five-/nine-point discrete Laplacian.
// Depends on dls_pkg, dls_line_store, dls_cell and dls_kernel.
//
//   port group | direction | carries
//   req_*      | in        | one grid sample word per handshake, raster order
//   rsp_*      | out       | one scaled Laplacian word per interior point
//   csr_*      | in        | register index and write data
//
// One word is taken per cycle unless the result side stalls, a rate the line store
// read port and the three-cell window chain keep by moving one column per word. A
// sample passes stage one, stage two and the kernel's registers to its result.
// Reset is synchronous and needs no clearing pass; the line store is not cleared.
// A stalled result holds the output register; the input stops once the two kernel
// stages, stage two and stage one are full. Border words skip the kernel, so only
// interior words fill it, and border words keep passing until then.
module discrete_laplacian_stencil_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dls_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dls_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dls_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [dls_pkg::GAIN_BITS-1:0] csr_data
);

   localparam int CB = dls_pkg::COL_BITS;
   localparam int RB = dls_pkg::ROW_BITS;
   localparam int DB = dls_pkg::DIM_BITS;
   localparam int SB = dls_pkg::SAMPLE_BITS;

   // Configuration registers; geometry is stored already clamped.
   dls_pkg::kernel_mode_type      kernel_mode_ff, kernel_mode_in;
   logic [dls_pkg::GAIN_BITS-1:0] inv_step_sq_ff, inv_step_sq_in;
   logic [DB-1:0]                 width_ff, width_in;
   logic [DB-1:0]                 height_ff, height_in;
   logic [DB-1:0]                 csr_dim;
   logic [DB-1:0]                 width_clamped, height_clamped;

   // Position counters.
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [CB-1:0] col_cur;
   logic [RB-1:0] row_cur;
   logic [DB-1:0] col_inc, row_inc;

   // Stage one: word waiting for its line store data.
   logic                          s1_v_ff, s1_v_in;
   logic signed [SB-1:0]          s1_sample_ff, s1_sample_in;
   logic [CB-1:0]                 s1_addr_ff, s1_addr_in;
   logic                          s1_emit_ff, s1_emit_in;
   dls_pkg::meta_type             s1_meta_ff, s1_meta_in;
   logic                          s1_fwd_ff, s1_fwd_in;
   dls_pkg::line_word_type        s1_fwd_word_ff, s1_fwd_word_in;

   // Stage two: window holds this word's neighborhood.
   logic                          s2_v_ff, s2_v_in;
   logic                          s2_emit_ff, s2_emit_in;
   dls_pkg::meta_type             s2_meta_ff, s2_meta_in;

   logic                          accept, s1_go, s2_leave, r2;
   logic                          emit_cur, end_cur;
   logic                          k_ready;
   dls_pkg::line_word_type        rd_word, line_eff, wr_word;
   dls_pkg::column_type           newest;
   dls_pkg::column_type           win [3];
   dls_pkg::meta_type             meta_cur;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_dim   = csr_data[DB-1:0];

   always_comb begin
      width_clamped  = csr_dim;
      height_clamped = csr_dim;
      if (csr_dim < dls_pkg::DIM_MIN) begin
         width_clamped  = dls_pkg::DIM_MIN;
         height_clamped = dls_pkg::DIM_MIN;
      end else begin
         if (csr_dim > DB'(dls_pkg::MAX_COLS)) begin
            width_clamped = DB'(dls_pkg::MAX_COLS);
         end
         if (csr_dim > DB'(dls_pkg::MAX_ROWS)) begin
            height_clamped = DB'(dls_pkg::MAX_ROWS);
         end
      end
   end

   always_comb begin
      kernel_mode_in = kernel_mode_ff;
      inv_step_sq_in = inv_step_sq_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dls_pkg::CSR_KERNEL_MODE: begin
               kernel_mode_in = dls_pkg::kernel_mode_type'(csr_data[0]);
            end
            dls_pkg::CSR_INV_STEP_SQ: begin
               inv_step_sq_in = csr_data;
            end
            dls_pkg::CSR_FRAME_WIDTH: begin
               width_in = width_clamped;
            end
            dls_pkg::CSR_FRAME_HEIGHT: begin
               height_in = height_clamped;
            end
            default: begin
               kernel_mode_in = kernel_mode_ff;
            end
         endcase
      end
   end

   // Handshake chain: each stage moves when the next is empty or emptying.
   assign s2_leave  = s2_v_ff && (!s2_emit_ff || k_ready);
   assign r2        = !s2_v_ff || s2_leave;
   assign s1_go     = s1_v_ff && r2;
   assign req_ready = !s1_v_ff || r2;
   assign accept    = req_valid && req_ready;

   // Position of the arriving word and its result flags.
   always_comb begin
      col_cur  = req_word.frame_start ? '0 : col_ff;
      row_cur  = req_word.frame_start ? '0 : row_ff;
      col_inc  = DB'(col_cur) + DB'(1);
      row_inc  = DB'(row_cur) + DB'(1);
      emit_cur = (col_cur >= CB'(2)) && (row_cur >= RB'(2))
              && (DB'(col_cur) < width_ff) && (DB'(row_cur) < height_ff);
      end_cur  = (DB'(col_cur) == width_ff - DB'(1))
              && (DB'(row_cur) == height_ff - DB'(1));
      meta_cur.col_index = col_cur - CB'(1);
      meta_cur.row_index = row_cur - RB'(1);
      meta_cur.frame_end = end_cur;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = (row_inc >= height_ff) ? '0 : row_inc[RB-1:0];
         end else begin
            col_in = col_inc[CB-1:0];
            row_in = row_cur;
         end
      end
   end

   // Line data for stage one; the word ahead may have written this entry
   // in the same cycle the read was issued, so its write is forwarded.
   always_comb begin
      line_eff       = s1_fwd_ff ? s1_fwd_word_ff : rd_word;
      wr_word.upper  = line_eff.middle;
      wr_word.middle = s1_sample_ff;
      newest.top     = line_eff.upper;
      newest.mid     = line_eff.middle;
      newest.bot     = s1_sample_ff;
   end

   always_comb begin
      s1_v_in        = s1_v_ff;
      s1_sample_in   = s1_sample_ff;
      s1_addr_in     = s1_addr_ff;
      s1_emit_in     = s1_emit_ff;
      s1_meta_in     = s1_meta_ff;
      s1_fwd_in      = s1_fwd_ff;
      s1_fwd_word_in = s1_fwd_word_ff;
      if (accept) begin
         s1_v_in        = 1'b1;
         s1_sample_in   = req_word.sample;
         s1_addr_in     = col_cur;
         s1_emit_in     = emit_cur;
         s1_meta_in     = meta_cur;
         s1_fwd_in      = s1_v_ff && (s1_addr_ff == col_cur);
         s1_fwd_word_in = wr_word;
      end else if (s1_go) begin
         s1_v_in = 1'b0;
      end
   end

   always_comb begin
      s2_v_in    = s2_v_ff;
      s2_emit_in = s2_emit_ff;
      s2_meta_in = s2_meta_ff;
      if (s1_go) begin
         s2_v_in    = 1'b1;
         s2_emit_in = s1_emit_ff;
         s2_meta_in = s1_meta_ff;
      end else if (s2_leave) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff <= dls_pkg::KERNEL_FIVE_POINT;
         inv_step_sq_ff <= dls_pkg::GAIN_RESET;
         width_ff       <= dls_pkg::WIDTH_RESET;
         height_ff      <= dls_pkg::HEIGHT_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
      end else begin
         kernel_mode_ff <= kernel_mode_in;
         inv_step_sq_ff <= inv_step_sq_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_v_ff        <= s1_v_in;
         s2_v_ff        <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff   <= s1_sample_in;
      s1_addr_ff     <= s1_addr_in;
      s1_emit_ff     <= s1_emit_in;
      s1_meta_ff     <= s1_meta_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_word_ff <= s1_fwd_word_in;
      s2_emit_ff     <= s2_emit_in;
      s2_meta_ff     <= s2_meta_in;
   end

   dls_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_word (rd_word),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_word (wr_word)
   );

   // Window: three column cells; the newest column enters at the right end.
   for (genvar i = 0; i < 3; i++) begin : g_cells
      dls_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (s1_go),
         .load_column ((i == 2) ? newest : win[(i + 1) % 3]),
         .held_column (win[i])
      );
   end

   dls_kernel u_kernel (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_v_ff && s2_emit_ff),
      .in_ready    (k_ready),
      .win_left    (win[0]),
      .win_center  (win[1]),
      .win_right   (win[2]),
      .in_meta     (s2_meta_ff),
      .kernel_mode (kernel_mode_ff),
      .inv_step_sq (inv_step_sq_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

FILE: src/dls_checker.sv
// Port checker for the stencil top level, attached by a bind statement.
// Depends on dls_pkg and discrete_laplacian_stencil_top_assert.svh.
`include "discrete_laplacian_stencil_top_assert.svh"

module dls_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input dls_pkg::rsp_word_type rsp_word
);

   logic rsp_waiting;
   logic rsp_interior;

   assign rsp_waiting  = rsp_valid && !rsp_ready;
   assign rsp_interior = (rsp_word.col_index != '0) && (rsp_word.row_index != '0);

   // A result word waiting for its taker holds still.
   `DLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_word))

   // No result may be presented right after reset.
   `DLS_ASSERT_AFTER_RESET(a_rsp_reset, clock, reset, !rsp_valid)

   // Only interior points produce results.
   `DLS_ASSERT_NOW(a_interior, clock, reset, rsp_valid, rsp_interior)

   // The input side may only be held off while a result is waiting.
   `DLS_ASSERT_NOW(a_no_idle_stall, clock, reset, !req_ready, rsp_valid)

endmodule

bind discrete_laplacian_stencil_top dls_checker u_dls_checker (.*);

FILE: tb/discrete_laplacian_stencil_top_tb.sv
// Self-checking testbench for the streaming five-/nine-point discrete Laplacian.
// Depends on dls_pkg and discrete_laplacian_stencil_top. A scoreboard class predicts
// every interior point from the accepted sample words and checks result words in order.
module discrete_laplacian_stencil_top_tb;
   import dls_pkg::*;

   // Quiet time at the end of settle(), enough to cover the block's pipeline.
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 700;
   localparam int WIDE_COLS     = 96;
   localparam int TALL_ROWS     = 96;

   // Scoreboard: keeps its own line stores, window, position counters and
   // registers, and holds the interior points still owed by the block.
   class laplace_scoreboard;
      kernel_mode_type       mode;
      logic [GAIN_BITS-1:0]  gain;
      logic [DIM_BITS-1:0]   width_reg;
      logic [DIM_BITS-1:0]   height_reg;
      logic signed [SAMPLE_BITS-1:0] upper_line [MAX_COLS];
      logic signed [SAMPLE_BITS-1:0] middle_line [MAX_COLS];
      logic signed [SAMPLE_BITS-1:0] win [3][3];
      int unsigned           col_pos;
      int unsigned           row_pos;
      rsp_word_type          expected_points [$];
      int                    errors;
      int                    points_checked;
      int                    samples_taken;

      function new();
         mode = KERNEL_FIVE_POINT;
         gain = GAIN_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         col_pos = 0;
         row_pos = 0;
         errors = 0;
         points_checked = 0;
         samples_taken = 0;
      endfunction

      function int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned grid_cols();
         return clamp_dim(width_reg, MAX_COLS);
      endfunction

      function int unsigned grid_rows();
         return clamp_dim(height_reg, MAX_ROWS);
      endfunction

      // Register write; indexes outside the map are dropped.
      function void write_reg(logic [IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
         case (idx)
            CSR_KERNEL_MODE:  mode = kernel_mode_type'(data[0]);
            CSR_INV_STEP_SQ:  gain = data;
            CSR_FRAME_WIDTH:  width_reg = data[DIM_BITS-1:0];
            CSR_FRAME_HEIGHT: height_reg = data[DIM_BITS-1:0];
            default: ;
         endcase
      endfunction

      // One accepted sample word: shift the window, update the line stores and,
      // once two rows and two columns are in, queue the point one up and one left.
      function void take_sample(req_word_type w);
         int unsigned cols;
         int unsigned rows;
         int unsigned c;
         int unsigned r;
         int unsigned slot;
         longint axial;
         longint diag;
         longint centre;
         longint kernel_sum;
         longint scaled;
         rsp_word_type point;
         cols = grid_cols();
         rows = grid_rows();
         samples_taken++;
         if (w.frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         c = col_pos;
         r = row_pos;
         slot = c % MAX_COLS;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = upper_line[slot];
         win[1][2] = middle_line[slot];
         win[2][2] = w.sample;
         upper_line[slot] = middle_line[slot];
         middle_line[slot] = w.sample;

         if (c >= 2 && r >= 2 && c < cols && r < rows) begin
            centre = win[1][1];
            axial = longint'(win[0][1]) + win[2][1] + win[1][0] + win[1][2];
            diag = longint'(win[0][0]) + win[0][2] + win[2][0] + win[2][2];
            // Kernel sum in quarter-LSB units, so both kernels stay exact.
            if (mode == KERNEL_FIVE_POINT)
               kernel_sum = 4 * (axial - 4 * centre);
            else
               kernel_sum = 2 * axial + diag - 12 * centre;
            // Scale, round half up, drop the ten fraction bits, then saturate.
            scaled = (kernel_sum * longint'(gain) + 512) >>> ROUND_SHIFT;
            if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
            if (scaled < -64'sd2147483648) scaled = -64'sd2147483648;
            point.laplace_value = scaled[VALUE_BITS-1:0];
            point.col_index = COL_BITS'(c - 1);
            point.row_index = ROW_BITS'(r - 1);
            point.frame_end = (c == cols - 1) && (r == rows - 1);
            expected_points.push_back(point);
         end

         // Advance the raster position; a counter beyond a shrunk size wraps here.
         c++;
         if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // One accepted result word against the oldest owed point.
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result: expected none, got value %0d col %0d row %0d end %0b",
                     $time, got.laplace_value, got.col_index, got.row_index, got.frame_end);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         compare_field("laplace_value", want.laplace_value, got.laplace_value);
         compare_field("col_index", want.col_index, got.col_index);
         compare_field("row_index", want.row_index, got.row_index);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IDX_BITS-1:0]    csr_index = '0;
   logic [GAIN_BITS-1:0]   csr_data = '0;

   laplace_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int configs_run = 0;
   int random_sent = 0;

   discrete_laplacian_stencil_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Result side stalls at the rate set for the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watch all three channels; accepted words feed the scoreboard, and a long
   // stretch with no word accepted anywhere ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_sample(req_word);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_word);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no word accepted for %0d cycles, %0d points still owed",
                     $time, QUIET_LIMIT, sb.expected_points.size());
            $display("discrete_laplacian_stencil_top_tb: errors");
            $finish;
         end
      end
   end

   // Mostly full-range values, with the extremes and zero mixed in.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return -16'sd1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Offer one sample word after a random gap; valid stays up after acceptance
   // so back-to-back words never drop it.
   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value, logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word.sample <= value;
      req_word.frame_start <= first;
      do @(posedge clock); while (!req_ready);
   endtask

   // One register write; the caller lowers valid after its last write.
   task automatic write_csr(logic [IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all four registers. Reports whether the grid gets wider, since then
   // the next sample must start a new grid so no unwritten store entry is read.
   task automatic configure(input logic [GAIN_BITS-1:0] mode_data, gain_data,
                            width_data, height_data, output bit widened);
      widened = sb.clamp_dim(width_data[DIM_BITS-1:0], MAX_COLS) > sb.grid_cols();
      write_csr(CSR_KERNEL_MODE, mode_data);
      write_csr(CSR_INV_STEP_SQ, gain_data);
      write_csr(CSR_FRAME_WIDTH, width_data);
      write_csr(CSR_FRAME_HEIGHT, height_data);
      csr_valid <= 1'b0;
      configs_run++;
   endtask

   // Let every owed point arrive, then give the pipeline time to empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A run of samples shaped as whole grids: frame start on most grid
   // boundaries, and now and then a restart in the middle of a grid.
   task automatic stream_items(int count, int grid_size, bit force_start, int noise_pct);
      bit first;
      for (int n = 0; n < count; n++) begin
         if (n == 0)
            first = force_start || ($urandom_range(99) < 70);
         else if (n % grid_size == 0)
            first = ($urandom_range(99) < 80);
         else
            first = ($urandom_range(99) < noise_pct);
         send_sample(pick_sample(), first);
      end
   endtask

   // One random setting on small grids. Phases often end mid-grid, so the next
   // setting changes the geometry while counters are mid-way.
   task automatic run_random_phase(int phase);
      logic [GAIN_BITS-1:0] width_data;
      logic [GAIN_BITS-1:0] height_data;
      logic [GAIN_BITS-1:0] gain_data;
      int unsigned cols;
      int unsigned rows;
      int count;
      bit widened;
      settle();
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 71; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 71; end
         default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      cols = ($urandom_range(99) < 85) ? $urandom_range(3, 10) : $urandom_range(11, 40);
      rows = $urandom_range(3, 6);
      width_data = GAIN_BITS'(cols);
      height_data = GAIN_BITS'(rows);
      // Now and then a size below the minimum, which the block raises to three.
      if ($urandom_range(99) < 8) begin
         width_data = GAIN_BITS'($urandom_range(2));
         cols = 3;
      end
      if ($urandom_range(99) < 8) begin
         height_data = GAIN_BITS'($urandom_range(2));
         rows = 3;
      end
      // Bits above the size field must be ignored.
      if ($urandom_range(99) < 25) width_data[GAIN_BITS-1:DIM_BITS] = 5'($urandom);
      if ($urandom_range(99) < 25) height_data[GAIN_BITS-1:DIM_BITS] = 5'($urandom);
      case ($urandom_range(9))
         0: gain_data = '0;
         1: gain_data = '1;
         default: gain_data = GAIN_BITS'($urandom);
      endcase
      configure(GAIN_BITS'($urandom), gain_data, width_data, height_data, widened);
      count = $urandom_range(1, 3) * cols * rows;
      if ($urandom_range(1)) count += $urandom_range(cols * rows - 1);
      stream_items(count, cols * rows, widened, 2);
      random_sent += count;
   endtask

   initial begin
      bit widened;
      int phase;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Five-point kernel at full gain on a 3x3 grid (sizes written below the
      // minimum): centre at one extreme, ring at the other.
      configure(16'h0000, 16'hFFFF, 16'h0000, 16'h0001, widened);
      for (int i = 0; i < 9; i++) send_sample((i == 4) ? 16'sh8000 : 16'sh7FFF, i == 0);
      // The next grid begins by position wrap alone, signs swapped.
      for (int i = 0; i < 9; i++) send_sample((i == 4) ? 16'sh7FFF : 16'sh8000, 1'b0);
      settle();

      // Writes to indexes past the register map must change nothing.
      for (int k = 1; k <= 4; k++)
         write_csr(IDX_BITS'(CSR_FRAME_HEIGHT) + IDX_BITS'(k), 16'hFFFF);
      // Nine-point kernel, unity gain, width with stray upper bits; two words,
      // then a frame start in the middle of the grid.
      configure(16'hFFFF, 16'h0100, 16'hF803, 16'h0003, widened);
      send_sample(pick_sample(), 1'b0);
      send_sample(pick_sample(), 1'b0);
      for (int i = 0; i < 9; i++)
         send_sample((i == 4 || i % 2 == 0) ? 16'sh8000 : 16'sh7FFF, i == 0);
      settle();

      // Wide grid, three rows: every interior column of it.
      idle_pct = 11;
      stall_pct = 11;
      configure(GAIN_BITS'($urandom), GAIN_BITS'($urandom), GAIN_BITS'(WIDE_COLS), 16'h0003,
                widened);
      stream_items(3 * WIDE_COLS, 3 * WIDE_COLS, 1'b1, 0);
      settle();

      // Height written past the maximum, three columns: the first rows of it.
      idle_pct = 0;
      stall_pct = 71;
      configure(GAIN_BITS'($urandom), GAIN_BITS'($urandom), 16'h0003, 16'hFFFF, widened);
      stream_items(3 * TALL_ROWS, 3 * TALL_ROWS, 1'b1, 0);

      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         run_random_phase(phase);
         phase++;
      end
      settle();

      $display("Checked %0d interior points from %0d sample words over %0d register settings,",
               sb.points_checked, sb.samples_taken, configs_run);
      $display("both kernels, clamped and extreme sizes, mid-grid restarts and four idle patterns.");
      if (sb.errors == 0 && sb.expected_points.size() == 0)
         $display("discrete_laplacian_stencil_top_tb: clean");
      else
         $display("discrete_laplacian_stencil_top_tb: errors");
      $finish;
   end

endmodule
